### rtl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies; imported by the top level and the divider cell.
package qrs_pkg;

    // Result field widths and the packed result bus.
    localparam int ROOT_BITS   = 36;
    localparam int OUT_TDATA_W = 80;

    localparam logic [63:0] ROOT_MAX_U = 64'd34359738367;
    localparam logic signed [ROOT_BITS-1:0] ROOT_MAX = 36'sh7_FFFF_FFFF;
    localparam logic signed [ROOT_BITS-1:0] ROOT_MIN = 36'sh8_0000_0000;

    // Root count codes.
    typedef enum logic [1:0] {
        CNT_NONE     = 2'd0,
        CNT_ONE      = 2'd1,
        CNT_TWO      = 2'd2,
        CNT_INFINITE = 2'd3
    } qrs_count_t;

    // Sideband that travels with a request through the divider row.
    typedef struct packed {
        qrs_count_t count;
        logic       neg1;
        logic       neg2;
    } qrs_side_t;

endpackage

### rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: coefficient registers, multipliers,
// a row of square root cells and a row of two-lane divider cells. Uses qrs_pkg.
//
// Channel | Direction | Payload (lowest bits first)
// s_      | in        | coef_a, coef_b, coef_c (COEF_BITS each, signed)
// m_      | out       | root_count (2), root_first (36), root_second (36)
//
// A request passes the coefficient registers, the product registers, one square root
// cell per root bit, one divider cell per quotient bit and the result register. A new
// request is taken in every cycle in which the result register is empty or being taken.
// Reset is synchronous and active low; it clears only the valid bits.
// When the result register holds a request that is not taken, the whole row holds.
module quadratic_root_solver #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // coef_a, coef_b, coef_c, then zero fill
    input  logic [((3*COEF_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // root_count [1:0], root_first [37:2], root_second [73:38], zero fill
    output logic [qrs_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import qrs_pkg::*;

    localparam int CB   = COEF_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = 2*CB + 3;       // signed discriminant width
    localparam int RB   = CB + 1 + F;     // square root result bits, one per cell
    localparam int SSW  = 3*CB + 2;       // sideband through the root row
    localparam int NW   = CB + F + 2;     // dividend magnitude, one bit per cell
    localparam int DDW  = CB + 1;         // divisor magnitude

    // The whole row advances together whenever the result register can move.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Coefficient registers.
    logic                 va_reg;
    logic signed [CB-1:0] a_reg, b_reg, c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= s_tdata[CB-1:0];
            b_reg <= s_tdata[2*CB-1:CB];
            c_reg <= s_tdata[3*CB-1:2*CB];
        end
    end

    // Products b*b and a*c, each registered.
    logic                   vb_reg;
    logic signed [2*CB-1:0] bb_reg, p_reg;
    logic signed [CB-1:0]   ab_reg, bb_coef_reg, cb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (adv) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bb_reg      <= b_reg * b_reg;
            p_reg       <= a_reg * c_reg;
            ab_reg      <= a_reg;
            bb_coef_reg <= b_reg;
            cb_reg      <= c_reg;
        end
    end

    // Discriminant and root count; this feeds the first square root cell.
    logic signed [DW-1:0] disc;
    logic                 disc_pos;
    qrs_count_t           count_c;
    logic [2*RB-1:0]      x_c;

    always_comb begin
        disc     = DW'(bb_reg) - (DW'(p_reg) <<< 2);
        disc_pos = !disc[DW-1] && (disc != '0);
        if (ab_reg == '0) begin
            if (bb_coef_reg == '0) begin
                count_c = (cb_reg == '0) ? CNT_INFINITE : CNT_NONE;
            end else begin
                count_c = CNT_ONE;
            end
        end else if (disc_pos) begin
            count_c = CNT_TWO;
        end else if (disc == '0) begin
            count_c = CNT_ONE;
        end else begin
            count_c = CNT_NONE;
        end
        // Only a positive discriminant with a nonzero a needs its root.
        x_c = (disc_pos && ab_reg != '0) ?
              ((2*RB)'(disc[2*CB:0]) << (2*F)) : '0;
    end

    // Square root row: each cell settles one bit of floor(sqrt(D) * 2^F).
    logic            sv [RB+1];
    logic [2*RB-1:0] sx [RB+1];
    logic [RB+2:0]   sr [RB+1];
    logic [RB-1:0]   sq [RB+1];
    logic [SSW-1:0]  ss [RB+1];

    assign sv[0] = vb_reg;
    assign sx[0] = x_c;
    assign sr[0] = '0;
    assign sq[0] = '0;
    assign ss[0] = {count_c, cb_reg, bb_coef_reg, ab_reg};

    for (genvar i = 0; i < RB; i++) begin : g_sqrt
        qrs_sqrt_cell #(.RB(RB), .SW(SSW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .vld_in   (sv[i]),
            .x_in     (sx[i]),
            .rem_in   (sr[i]),
            .root_in  (sq[i]),
            .side_in  (ss[i]),
            .vld_out  (sv[i+1]),
            .x_out    (sx[i+1]),
            .rem_out  (sr[i+1]),
            .root_out (sq[i+1]),
            .side_out (ss[i+1])
        );
    end

    // Numerators and divisor for both roots, split into sign and magnitude.
    logic signed [CB-1:0] a_e, b_e, c_e;
    qrs_count_t           count_e;
    logic signed [NW:0]   s_x, nb, num1, num2;
    logic signed [CB+1:0] den;
    logic [NW-1:0]        mag1, mag2;
    logic [DDW-1:0]       dmag;
    qrs_side_t            side_e;

    always_comb begin
        a_e     = ss[RB][CB-1:0];
        b_e     = ss[RB][2*CB-1:CB];
        c_e     = ss[RB][3*CB-1:2*CB];
        count_e = qrs_count_t'(ss[RB][3*CB+1:3*CB]);
        s_x     = $signed((NW+1)'(sq[RB]));
        nb      = -((NW+1)'(b_e) <<< F);
        if (a_e == '0) begin
            // Linear case: -c / b.
            num1 = -((NW+1)'(c_e) <<< F);
            den  = (CB+2)'(b_e);
        end else begin
            num1 = nb - s_x;
            den  = (CB+2)'(a_e) <<< 1;
        end
        num2        = nb + s_x;
        mag1        = num1[NW] ? NW'(-num1) : NW'(num1);
        mag2        = num2[NW] ? NW'(-num2) : NW'(num2);
        dmag        = den[CB+1] ? DDW'(-den) : DDW'(den);
        side_e.count = count_e;
        side_e.neg1  = num1[NW] ^ den[CB+1];
        side_e.neg2  = num2[NW] ^ den[CB+1];
    end

    // Divider row: both quotients, one bit per cell, sharing the divisor.
    logic           dv  [NW+1];
    logic [NW-1:0]  dn1 [NW+1];
    logic [NW-1:0]  dn2 [NW+1];
    logic [DDW-1:0] dr1 [NW+1];
    logic [DDW-1:0] dr2 [NW+1];
    logic [DDW-1:0] dd  [NW+1];
    qrs_side_t      dsd [NW+1];

    assign dv[0]  = sv[RB];
    assign dn1[0] = mag1;
    assign dn2[0] = mag2;
    assign dr1[0] = '0;
    assign dr2[0] = '0;
    assign dd[0]  = dmag;
    assign dsd[0] = side_e;

    for (genvar j = 0; j < NW; j++) begin : g_div
        qrs_div_cell #(.NW(NW), .DDW(DDW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .vld_in   (dv[j]),
            .n1_in    (dn1[j]),
            .n2_in    (dn2[j]),
            .r1_in    (dr1[j]),
            .r2_in    (dr2[j]),
            .d_in     (dd[j]),
            .side_in  (dsd[j]),
            .vld_out  (dv[j+1]),
            .n1_out   (dn1[j+1]),
            .n2_out   (dn2[j+1]),
            .r1_out   (dr1[j+1]),
            .r2_out   (dr2[j+1]),
            .d_out    (dd[j+1]),
            .side_out (dsd[j+1])
        );
    end

    // Saturate, apply the sign and zero the unused roots.
    logic [63:0]                 q1_w, q2_w;
    logic signed [ROOT_BITS-1:0] r1_f, r2_f, r1_o, r2_o;
    qrs_side_t                   side_f;

    always_comb begin
        side_f = dsd[NW];
        q1_w   = 64'(dn1[NW]);
        q2_w   = 64'(dn2[NW]);
        if (q1_w > ROOT_MAX_U) begin
            r1_f = side_f.neg1 ? ROOT_MIN : ROOT_MAX;
        end else begin
            r1_f = side_f.neg1 ? -$signed(q1_w[ROOT_BITS-1:0]) : $signed(q1_w[ROOT_BITS-1:0]);
        end
        if (q2_w > ROOT_MAX_U) begin
            r2_f = side_f.neg2 ? ROOT_MIN : ROOT_MAX;
        end else begin
            r2_f = side_f.neg2 ? -$signed(q2_w[ROOT_BITS-1:0]) : $signed(q2_w[ROOT_BITS-1:0]);
        end
        r1_o = (side_f.count == CNT_ONE || side_f.count == CNT_TWO) ? r1_f : '0;
        r2_o = (side_f.count == CNT_TWO) ? r2_f : '0;
    end

    // Result register.
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= OUT_TDATA_W'({r2_o, r1_o, side_f.count});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A waiting result stops the intake.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the result register is stalled");

    // The second root is zero unless two roots are reported.
    a_second_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != CNT_TWO |-> m_tdata[73:38] == '0)
        else $error("second root set without two roots");

    // No root is reported when there are none or infinitely many.
    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == CNT_NONE || m_tdata[1:0] == CNT_INFINITE)
        |-> m_tdata[37:2] == '0)
        else $error("first root set without a single or double root");
endmodule

### rtl/qrs_sqrt_cell.sv
// One digit cell of the square root row: one result bit per cell.
// Depends on nothing but its parameters.
module qrs_sqrt_cell #(
    parameter int RB = 33,
    parameter int SW = 50
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vld_in,
    input  logic [2*RB-1:0]   x_in,
    input  logic [RB+2:0]     rem_in,
    input  logic [RB-1:0]     root_in,
    input  logic [SW-1:0]     side_in,
    output logic              vld_out,
    output logic [2*RB-1:0]   x_out,
    output logic [RB+2:0]     rem_out,
    output logic [RB-1:0]     root_out,
    output logic [SW-1:0]     side_out
);
    logic [RB+2:0] rem_sh;
    logic [RB+2:0] trial;
    logic          ge;
    logic          vld_reg;
    logic [2*RB-1:0] x_reg;
    logic [RB+2:0]   rem_reg;
    logic [RB-1:0]   root_reg;
    logic [SW-1:0]   side_reg;

    always_comb begin
        rem_sh = {rem_in[RB:0], x_in[2*RB-1 -: 2]};
        trial  = (RB+3)'({root_in, 2'b01});
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_in << 2;
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_in[RB-2:0], ge};
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;
endmodule

### rtl/qrs_div_cell.sv
// One restoring division cell, two lanes sharing a divisor: one quotient bit per lane.
// Uses qrs_pkg for the sideband type.
module qrs_div_cell #(
    parameter int NW  = 34,
    parameter int DDW = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vld_in,
    input  logic [NW-1:0]       n1_in,
    input  logic [NW-1:0]       n2_in,
    input  logic [DDW-1:0]      r1_in,
    input  logic [DDW-1:0]      r2_in,
    input  logic [DDW-1:0]      d_in,
    input  qrs_pkg::qrs_side_t  side_in,
    output logic                vld_out,
    output logic [NW-1:0]       n1_out,
    output logic [NW-1:0]       n2_out,
    output logic [DDW-1:0]      r1_out,
    output logic [DDW-1:0]      r2_out,
    output logic [DDW-1:0]      d_out,
    output qrs_pkg::qrs_side_t  side_out
);
    import qrs_pkg::*;

    logic [DDW:0] sh1, sh2, dx;
    logic         ge1, ge2;
    logic         vld_reg;
    logic [NW-1:0]  n1_reg, n2_reg;
    logic [DDW-1:0] r1_reg, r2_reg, d_reg;
    qrs_side_t      side_reg;

    always_comb begin
        sh1 = {r1_in, n1_in[NW-1]};
        sh2 = {r2_in, n2_in[NW-1]};
        dx  = {1'b0, d_in};
        ge1 = (sh1 >= dx);
        ge2 = (sh2 >= dx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg   <= DDW'(ge1 ? (sh1 - dx) : sh1);
            r2_reg   <= DDW'(ge2 ? (sh2 - dx) : sh2);
            n1_reg   <= {n1_in[NW-2:0], ge1};
            n2_reg   <= {n2_in[NW-2:0], ge2};
            d_reg    <= d_in;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign n1_out   = n1_reg;
    assign n2_out   = n2_reg;
    assign r1_out   = r1_reg;
    assign r2_out   = r2_reg;
    assign d_out    = d_reg;
    assign side_out = side_reg;
endmodule
